// ===== rtl/tets_pkg.sv =====
// shared types, codes and constants of the timed event table scheduler
package tets_pkg;

   localparam int SLOTS_DEF = 16;

   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_ADD        = 3'd1;
   localparam logic [2:0] CMD_REMOVE     = 3'd2;
   localparam logic [2:0] CMD_ENABLE     = 3'd3;
   localparam logic [2:0] CMD_DISABLE    = 3'd4;
   localparam logic [2:0] CMD_REMOVE_ALL = 3'd5;
   localparam logic [2:0] CMD_SET_TIME   = 3'd6;
   localparam logic [2:0] CMD_READ_SLOT  = 3'd7;

   localparam logic [2:0] KIND_ACK        = 3'd0;
   localparam logic [2:0] KIND_FIRE_START = 3'd1;
   localparam logic [2:0] KIND_FIRE_MAIN  = 3'd2;
   localparam logic [2:0] KIND_FIRE_STOP  = 3'd3;
   localparam logic [2:0] KIND_TICK_DONE  = 3'd4;

   localparam logic [1:0] BASE_ABS    = 2'd0;
   localparam logic [1:0] BASE_NOW    = 2'd1;
   localparam logic [1:0] BASE_ORIGIN = 2'd2;

   localparam logic [4:0] NO_SLOT = 5'd16;

   typedef struct packed {
      logic [31:0] time_v;
      logic [31:0] period;
      logic [15:0] count;
      logic [15:0] done;
      logic [15:0] arg;
      logic [7:0]  action;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] rem;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACK,
      ST_P1,
      ST_P2,
      ST_DIV,
      ST_FIRE,
      ST_START,
      ST_MAIN,
      ST_STOP,
      ST_WB,
      ST_TDONE
   } state_type;

endpackage

// ===== rtl/timed_event_table_scheduler_top.sv =====
// top level of the timed event table scheduler
// commands other than tick: decoded in EXEC, result registered and emitted from ACK; ready again after that
// tick: a counting pass over all slots (P1), a firing pass (P2), then tick_done; ready again after it
// a due slot passes through FIRE, START/MAIN/STOP and WB, plus the remainder unit for a nonzero period
// an output stall holds the emitting state; one command in flight, the slot table lives in one ram
// synchronous reset frees all slots at once and clears the time; no clearing pass
module timed_event_table_scheduler_top #(
   parameter int SLOTS = tets_pkg::SLOTS_DEF,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // slot, action, time_value, time_base, period, count, infinite, arg,
   // notify_start, notify_stop, check_action
   input  logic [119:0] req_tdata,
   // cmd
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_out, action_out, arg_out, value, ok, slot_enabled, active_count
   output logic [71:0]  rsp_tdata,
   // kind
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   tets_pkg::state_type state_ff, state_in;
   logic [119:0] q_ff, q_in;
   logic [2:0]   cmd_ff, cmd_in;
   logic [31:0]  now_ff, now_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [4:0]   dec_ff, dec_in;
   logic [4:0]   act_ff, act_in;
   tets_pkg::entry_type rec_ff, rec_in;
   logic [SLOTS-1:0] free_ff, free_in, en_ff, en_in, inf_ff, inf_in;
   logic [SLOTS-1:0] st_ff, st_in, sp_ff, sp_in;
   logic [4:0]   ack_slot_ff, ack_slot_in;
   logic [7:0]   ack_action_ff, ack_action_in;
   logic [15:0]  ack_arg_ff, ack_arg_in;
   logic [31:0]  ack_value_ff, ack_value_in;
   logic         ack_ok_ff, ack_ok_in, ack_en_ff, ack_en_in;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]   rsp_tuser_ff, rsp_tuser_in;
   logic         rsp_tlast_ff, rsp_tlast_in;

   logic [4:0]  q_slot;
   logic [7:0]  q_action;
   logic [31:0] q_tv, q_period;
   logic [1:0]  q_base;
   logic [15:0] q_count, q_arg;
   logic        q_inf, q_ns, q_nst, q_chk, q_valid;
   logic [SW-1:0] q_sidx, cur_idx, fs;
   logic        found;

   logic                ram_we;
   logic [SW-1:0]       ram_waddr, ram_raddr;
   tets_pkg::entry_type ram_wdata;
   logic [tets_pkg::ENTRY_W-1:0] ram_rdata;
   tets_pkg::entry_type rdat, rd_rec;
   tets_pkg::div_ctl_type  div_ctl;
   tets_pkg::div_stat_type div_stat;

   logic        due, exh, idx_last, can_emit, emit, match, good;
   logic [4:0]  popcnt;
   logic [15:0] done_new;
   logic [31:0] t_add;
   logic [2:0]  em_kind;
   logic [4:0]  em_slot, em_act;
   logic [7:0]  em_action;
   logic [15:0] em_arg;
   logic [31:0] em_value;
   logic        em_ok, em_en, em_last;

   assign q_slot   = q_ff[4:0];
   assign q_action = q_ff[12:5];
   assign q_tv     = q_ff[44:13];
   assign q_base   = q_ff[46:45];
   assign q_period = q_ff[78:47];
   assign q_count  = q_ff[94:79];
   assign q_inf    = q_ff[95];
   assign q_arg    = q_ff[111:96];
   assign q_ns     = q_ff[112];
   assign q_nst    = q_ff[113];
   assign q_chk    = q_ff[114];
   assign q_valid  = (q_slot < 5'(SLOTS));
   assign q_sidx   = q_slot[SW-1:0];

   tets_ram #(
      .WIDTH (tets_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tets_rem_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   assign rdat     = tets_pkg::entry_type'(ram_rdata);
   assign cur_idx  = (state_ff == tets_pkg::ST_EXEC) ? q_sidx : idx_ff;
   assign rd_rec   = free_ff[cur_idx] ? '0 : rdat;
   assign due      = !free_ff[idx_ff] && (rd_rec.time_v <= now_ff);
   assign exh      = !inf_ff[idx_ff] && (rd_rec.done >= rd_rec.count);
   assign idx_last = (idx_ff == SW'(SLOTS - 1));
   assign can_emit = !rsp_tvalid_ff || rsp_tready;
   assign match    = !q_chk || (rd_rec.action == q_action);
   assign done_new = (rec_ff.done == 16'hFFFF) ? rec_ff.done : rec_ff.done + 16'd1;

   always_comb begin
      popcnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         popcnt = popcnt + 5'(!free_ff[i] && en_ff[i]);
      end
   end

   always_comb begin
      found = 1'b0;
      fs    = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            found = 1'b1;
            fs    = SW'(i);
         end
      end
   end

   always_comb begin
      unique case (q_base)
         tets_pkg::BASE_NOW:    t_add = now_ff + q_tv;
         tets_pkg::BASE_ORIGIN: t_add = rd_rec.time_v + q_tv;
         default:               t_add = q_tv;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      dec_in        = dec_ff;
      act_in        = act_ff;
      rec_in        = rec_ff;
      free_in       = free_ff;
      en_in         = en_ff;
      inf_in        = inf_ff;
      st_in         = st_ff;
      sp_in         = sp_ff;
      ack_slot_in   = ack_slot_ff;
      ack_action_in = ack_action_ff;
      ack_arg_in    = ack_arg_ff;
      ack_value_in  = ack_value_ff;
      ack_ok_in     = ack_ok_ff;
      ack_en_in     = ack_en_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = rec_ff;
      ram_raddr     = idx_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = now_ff - rd_rec.time_v;
      div_ctl.divisor  = rd_rec.period;
      good      = 1'b0;
      emit      = 1'b0;
      em_kind   = tets_pkg::KIND_FIRE_MAIN;
      em_slot   = 5'(idx_ff);
      em_action = rec_ff.action;
      em_arg    = rec_ff.arg;
      em_value  = now_ff;
      em_ok     = 1'b1;
      em_en     = 1'b0;
      em_act    = act_ff;
      em_last   = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         tets_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_raddr  = req_tdata[SW-1:0];
            if (req_tvalid) begin
               q_in   = req_tdata;
               cmd_in = req_tuser;
               if (req_tuser == tets_pkg::CMD_TICK) begin
                  now_in    = now_ff + 32'd1;
                  idx_in    = '0;
                  dec_in    = '0;
                  ram_raddr = '0;
                  state_in  = tets_pkg::ST_P1;
               end else begin
                  state_in = tets_pkg::ST_EXEC;
               end
            end
         end

         tets_pkg::ST_EXEC: begin
            ack_slot_in   = q_slot;
            ack_action_in = '0;
            ack_arg_in    = '0;
            ack_value_in  = now_ff;
            ack_ok_in     = 1'b0;
            ack_en_in     = 1'b0;
            state_in      = tets_pkg::ST_ACK;
            unique case (cmd_ff) inside
               tets_pkg::CMD_ADD: begin
                  good = found && (q_base == tets_pkg::BASE_ABS || q_base == tets_pkg::BASE_NOW
                         || (q_base == tets_pkg::BASE_ORIGIN && q_valid));
                  if (good) begin
                     ram_we           = 1'b1;
                     ram_waddr        = fs;
                     ram_wdata.time_v = t_add;
                     ram_wdata.period = q_period;
                     ram_wdata.count  = q_inf ? 16'd0 : q_count;
                     ram_wdata.done   = '0;
                     ram_wdata.arg    = q_arg;
                     ram_wdata.action = q_action;
                     free_in[fs]      = 1'b0;
                     en_in[fs]        = 1'b1;
                     inf_in[fs]       = q_inf;
                     st_in[fs]        = q_ns;
                     sp_in[fs]        = !q_inf && q_nst;
                     ack_slot_in      = 5'(fs);
                     ack_action_in    = q_action;
                     ack_arg_in       = q_arg;
                     ack_ok_in        = 1'b1;
                  end else begin
                     ack_slot_in = tets_pkg::NO_SLOT;
                  end
               end
               tets_pkg::CMD_REMOVE: begin
                  good      = q_valid && match;
                  ack_ok_in = good;
                  if (good) begin
                     free_in[q_sidx] = 1'b1;
                     en_in[q_sidx]   = 1'b0;
                     inf_in[q_sidx]  = 1'b0;
                     st_in[q_sidx]   = 1'b0;
                     sp_in[q_sidx]   = 1'b0;
                  end
               end
               tets_pkg::CMD_ENABLE, tets_pkg::CMD_DISABLE: begin
                  good      = q_valid && !free_ff[q_sidx] && match;
                  ack_ok_in = good;
                  if (good) begin
                     en_in[q_sidx] = (cmd_ff == tets_pkg::CMD_ENABLE);
                  end
               end
               tets_pkg::CMD_REMOVE_ALL: begin
                  free_in     = '1;
                  en_in       = '0;
                  inf_in      = '0;
                  st_in       = '0;
                  sp_in       = '0;
                  ack_slot_in = tets_pkg::NO_SLOT;
                  ack_ok_in   = 1'b1;
               end
               tets_pkg::CMD_SET_TIME: begin
                  now_in       = q_tv;
                  ack_value_in = q_tv;
                  ack_slot_in  = tets_pkg::NO_SLOT;
                  ack_ok_in    = 1'b1;
               end
               default: begin
                  if (q_valid) begin
                     ack_action_in = rd_rec.action;
                     ack_arg_in    = rd_rec.arg;
                     ack_value_in  = rd_rec.time_v;
                     ack_ok_in     = 1'b1;
                     ack_en_in     = en_ff[q_sidx] && !free_ff[q_sidx];
                  end else begin
                     ack_value_in = '0;
                  end
               end
            endcase
         end

         tets_pkg::ST_ACK: begin
            em_kind   = tets_pkg::KIND_ACK;
            em_slot   = ack_slot_ff;
            em_action = ack_action_ff;
            em_arg    = ack_arg_ff;
            em_value  = ack_value_ff;
            em_ok     = ack_ok_ff;
            em_en     = ack_en_ff;
            em_act    = popcnt;
            em_last   = 1'b1;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = tets_pkg::ST_IDLE;
            end
         end

         tets_pkg::ST_P1: begin
            if (due && exh && en_ff[idx_ff]) begin
               dec_in = dec_ff + 5'd1;
            end
            if (idx_last) begin
               act_in    = popcnt - dec_in;
               idx_in    = '0;
               ram_raddr = '0;
               state_in  = tets_pkg::ST_P2;
            end else begin
               idx_in    = idx_ff + SW'(1);
               ram_raddr = idx_ff + SW'(1);
            end
         end

         tets_pkg::ST_P2: begin
            rec_in = rd_rec;
            if (due && !exh) begin
               if (rd_rec.period != '0) begin
                  div_ctl.start = 1'b1;
                  state_in      = tets_pkg::ST_DIV;
               end else begin
                  state_in = tets_pkg::ST_FIRE;
               end
            end else begin
               if (due) begin
                  free_in[idx_ff] = 1'b1;
                  en_in[idx_ff]   = 1'b0;
                  inf_in[idx_ff]  = 1'b0;
                  st_in[idx_ff]   = 1'b0;
                  sp_in[idx_ff]   = 1'b0;
               end
               if (idx_last) begin
                  state_in = tets_pkg::ST_TDONE;
               end else begin
                  idx_in    = idx_ff + SW'(1);
                  ram_raddr = idx_ff + SW'(1);
               end
            end
         end

         tets_pkg::ST_DIV: begin
            if (div_stat.done) begin
               rec_in.time_v = now_ff - div_stat.rem + rec_ff.period;
               state_in      = tets_pkg::ST_FIRE;
            end
         end

         tets_pkg::ST_FIRE: begin
            if (!en_ff[idx_ff]) begin
               state_in = tets_pkg::ST_WB;
            end else if (st_ff[idx_ff] && rec_ff.done == '0) begin
               state_in = tets_pkg::ST_START;
            end else begin
               state_in = tets_pkg::ST_MAIN;
            end
         end

         tets_pkg::ST_START: begin
            em_kind = tets_pkg::KIND_FIRE_START;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = tets_pkg::ST_MAIN;
            end
         end

         tets_pkg::ST_MAIN: begin
            em_kind = tets_pkg::KIND_FIRE_MAIN;
            if (can_emit) begin
               emit        = 1'b1;
               rec_in.done = done_new;
               if (sp_ff[idx_ff] && done_new == rec_ff.count) begin
                  state_in = tets_pkg::ST_STOP;
               end else begin
                  state_in = tets_pkg::ST_WB;
               end
            end
         end

         tets_pkg::ST_STOP: begin
            em_kind = tets_pkg::KIND_FIRE_STOP;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = tets_pkg::ST_WB;
            end
         end

         tets_pkg::ST_WB: begin
            ram_we = 1'b1;
            if (idx_last) begin
               state_in = tets_pkg::ST_TDONE;
            end else begin
               idx_in    = idx_ff + SW'(1);
               ram_raddr = idx_ff + SW'(1);
               state_in  = tets_pkg::ST_P2;
            end
         end

         tets_pkg::ST_TDONE: begin
            em_kind   = tets_pkg::KIND_TICK_DONE;
            em_slot   = tets_pkg::NO_SLOT;
            em_action = '0;
            em_arg    = '0;
            em_last   = 1'b1;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = tets_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tets_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {4'd0, em_act, em_en, em_ok, em_value, em_arg, em_action, em_slot};
         rsp_tuser_in  = em_kind;
         rsp_tlast_in  = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tets_pkg::ST_IDLE;
         now_ff        <= '0;
         free_ff       <= '1;
         en_ff         <= '0;
         inf_ff        <= '0;
         st_ff         <= '0;
         sp_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         free_ff       <= free_in;
         en_ff         <= en_in;
         inf_ff        <= inf_in;
         st_ff         <= st_in;
         sp_ff         <= sp_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      q_ff          <= q_in;
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      dec_ff        <= dec_in;
      act_ff        <= act_in;
      rec_ff        <= rec_in;
      ack_slot_ff   <= ack_slot_in;
      ack_action_ff <= ack_action_in;
      ack_arg_ff    <= ack_arg_in;
      ack_value_ff  <= ack_value_in;
      ack_ok_ff     <= ack_ok_in;
      ack_en_ff     <= ack_en_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tlast_ff  <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== rtl/tets_ram.sv =====
// generic single write port ram with registered read
module tets_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tets_rem_div.sv =====
// bit-serial restoring remainder unit, one bit per cycle
module tets_rem_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tets_pkg::div_ctl_type ctl,
   output tets_pkg::div_stat_type stat
);

   logic [31:0] n_ff, n_in;
   logic [31:0] d_ff, d_in;
   logic [31:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff, n_ff[31]};
      if (ctl.start) begin
         n_in    = ctl.dividend;
         d_in    = ctl.divisor;
         r_in    = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[30:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = 32'(trial - {1'b0, d_ff});
         end else begin
            r_in = trial[31:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign stat.done = done_ff;
   assign stat.rem  = r_ff;

endmodule

// ===== rtl/tets_checker.sv =====
// port-level checks of the scheduler top and their binding
module tets_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [119:0] req_tdata,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one command at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");

   // tick summary closes the tick
   a_tick_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tets_pkg::KIND_TICK_DONE |-> rsp_tlast)
      else $error("tick_done without last");

   // only a final result may wait while a new command is open
   a_idle_pending_last: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("ready while a step is still emitting");

endmodule

bind timed_event_table_scheduler_top tets_checker u_tets_checker (.*);
